// ===== rtl/bsws_pkg.sv =====
// Shared types and constants for the bounded stack with search.
package bsws_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatW    = 3;
  localparam int unsigned PosW     = 3;
  localparam int unsigned DefDepth = 8;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_POPPED   = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_ENTRY    = 3'd6
  } status_e;

  typedef struct packed {
    logic load;    // take the pushed word
    logic rotate;  // move one place towards the bottom
    logic tail;    // topmost held entry: refill from the bottom cell
  } cell_ctrl_t;

endpackage

// ===== rtl/bsws_if.sv =====
// Handshake interfaces for the command and result channels.
interface bsws_in_if;
  logic                                valid;
  logic                                ready;
  logic [bsws_pkg::OpW-1:0]            opcode;
  logic signed [bsws_pkg::DataW-1:0]   operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface bsws_out_if;
  logic                                valid;
  logic                                ready;
  logic [bsws_pkg::StatW-1:0]          status;
  logic signed [bsws_pkg::DataW-1:0]   data_value;
  logic [bsws_pkg::PosW-1:0]           position;
  logic                                last;

  modport source (output valid, output status, output data_value, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data_value, input position,
                  input last, output ready);
endinterface

// ===== rtl/bsws_cell.sv =====
// One stack cell: holds a single entry and passes it down the ring on a walk.
module bsws_cell (
  input  logic                 clk_i,
  input  bsws_pkg::cell_ctrl_t ctrl_i,
  input  bsws_pkg::data_t      load_data_i,
  input  bsws_pkg::data_t      nbr_i,
  input  bsws_pkg::data_t      head_i,
  output bsws_pkg::data_t      data_o
);
  import bsws_pkg::*;

  data_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.rotate) begin
      data_d = ctrl_i.tail ? head_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bounded_stack_with_search.sv =====
// Bounded LIFO stack with search and listing, built as a ring of entry cells.
//
//   port    dir  words                     role
//   in_i    in   opcode, operand_value     command word
//   out_o   out  status, data_value,       result word, last marks the final
//                position, last            result of a command
//
// Push and pop answer straight from idle, with no walk. Search and list rotate
// the held entries through the bottom cell, one entry a cycle while the output
// register is free. A list gives one result per entry; a search ends with a
// closing result. Reset empties the stack; entry data is not cleared.
// A full output register stalls the walk; commands are taken only when idle.
module bounded_stack_with_search #(
  parameter int unsigned Depth = bsws_pkg::DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsws_in_if.sink     in_i,
  bsws_out_if.source  out_o
);
  import bsws_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFinal
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] walk_q, walk_d;
  logic            list_q, list_d;
  data_t           key_q, key_d;
  logic            pend_v_q, pend_v_d;
  logic [PosW-1:0] pend_pos_q, pend_pos_d;

  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  data_t           out_data_q, out_data_d;
  logic [PosW-1:0] out_pos_q, out_pos_d;
  logic            out_last_q, out_last_d;

  data_t           cell_q [Depth];
  cell_ctrl_t      cell_ctrl [Depth];

  logic            out_free, in_go, is_empty, is_full, walk_end;
  logic            push_go, step;
  logic [IdxW-1:0] top_idx;
  data_t           head, top;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && out_free;
  assign in_go = in_i.valid && in_i.ready;
  assign is_empty = (count_q == '0);
  assign is_full = (count_q == CntW'(Depth));
  assign walk_end = (walk_q == count_q - CntW'(1));
  assign top_idx = IdxW'(count_q - CntW'(1));
  assign head = cell_q[0];
  assign top = cell_q[top_idx];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    walk_d       = walk_q;
    list_d       = list_q;
    key_d        = key_q;
    pend_v_d     = pend_v_q;
    pend_pos_d   = pend_pos_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;
    push_go      = 1'b0;
    step         = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_go) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_pos_d   = '0;
          out_last_d  = 1'b1;
          case (opcode_e'(in_i.opcode))
            OP_PUSH: begin
              if (is_full) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_PUSHED;
                push_go      = 1'b1;
                count_d      = count_q + CntW'(1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_status_d = ST_POPPED;
                out_data_d   = top;
                count_d      = count_q - CntW'(1);
              end
            end
            default: begin
              if (is_empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_valid_d = out_valid_q && !out_o.ready;
                state_d     = StWalk;
                walk_d      = '0;
                list_d      = (opcode_e'(in_i.opcode) == OP_LIST);
                key_d       = in_i.operand_value;
                pend_v_d    = 1'b0;
              end
            end
          endcase
        end
      end
      StWalk: begin
        if (out_free) begin
          step   = 1'b1;
          walk_d = walk_q + CntW'(1);
          if (list_q) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_ENTRY;
            out_data_d   = head;
            out_pos_d    = PosW'(walk_q);
            out_last_d   = walk_end;
          end else if (head == key_q) begin
            // a match is held back until the next one shows it was not the last
            if (pend_v_q) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_FOUND;
              out_data_d   = '0;
              out_pos_d    = pend_pos_q;
              out_last_d   = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_pos_d = PosW'(walk_q);
          end
          if (walk_end) begin
            state_d = list_q ? StIdle : StFinal;
          end
        end
      end
      StFinal: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_v_q ? ST_FOUND : ST_NOTFOUND;
          out_data_d   = '0;
          out_pos_d    = pend_v_q ? pend_pos_q : '0;
          out_last_d   = 1'b1;
          pend_v_d     = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      walk_q       <= '0;
      list_q       <= 1'b0;
      key_q        <= '0;
      pend_v_q     <= 1'b0;
      pend_pos_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_PUSHED;
      out_data_q   <= '0;
      out_pos_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      walk_q       <= walk_d;
      list_q       <= list_d;
      key_q        <= key_d;
      pend_v_q     <= pend_v_d;
      pend_pos_q   <= pend_pos_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_pos_q    <= out_pos_d;
      out_last_q   <= out_last_d;
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    assign cell_ctrl[g].load   = push_go && (count_q == CntW'(g));
    assign cell_ctrl[g].rotate = step && (CntW'(g) < count_q);
    assign cell_ctrl[g].tail   = (CntW'(g + 1) == count_q);

    bsws_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .load_data_i (in_i.operand_value),
      .nbr_i       (cell_q[(g + 1) % Depth]),
      .head_i      (cell_q[0]),
      .data_o      (cell_q[g])
    );
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.data_value = out_data_q;
  assign out_o.position   = out_pos_q;
  assign out_o.last       = out_last_q;

endmodule
